>>> rtl/bqs_pkg.sv
// bqs_pkg: shared types and codes for the bounded queue of stacks
// used by every rtl file of the block but bqs_ram; no dependencies
`timescale 1ns / 1ps

package bqs_pkg;

  // fixed field widths
  localparam int TAG_W = 16;
  localparam int CFG_W = 5;

  // command codes
  localparam logic CMD_STORE    = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // configuration register indexes
  localparam logic CFG_STACK_COUNT  = 1'b0;
  localparam logic CFG_STACK_HEIGHT = 1'b1;

  // reset value of both limit registers
  localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd16;

  // status of one item as it leaves the control stage
  typedef struct packed {
    logic ok;
    logic tag_vld;
    logic is_empty;
    logic is_full;
  } bqs_res_t;

  // one finished result item
  typedef struct packed {
    logic             ok;
    logic [TAG_W-1:0] tag;
    logic             is_empty;
    logic             is_full;
  } bqs_out_t;

endpackage

>>> rtl/bqs_ram.sv
// bqs_ram: generic one-write one-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bqs_ctrl.sv
// bqs_ctrl: limit registers, ring pointers, fill tracking and slot addressing
// depends on bqs_pkg and bqs_ram (per-stack fill store)
`timescale 1ns / 1ps

module bqs_ctrl import bqs_pkg::*; #(
  parameter int MAX_STACKS = 16,
  parameter int MAX_HEIGHT = 16,
  parameter int AW = (MAX_STACKS * MAX_HEIGHT > 1) ? $clog2(MAX_STACKS * MAX_HEIGHT) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_accept,
  input  logic             in_command,
  input  logic [TAG_W-1:0] in_tag,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             slot_we,
  output logic [AW-1:0]    slot_waddr,
  output logic [TAG_W-1:0] slot_wdata,
  output logic [AW-1:0]    slot_raddr,
  output logic             res_valid,
  output bqs_res_t         res
);

  localparam int SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int CW = $clog2(MAX_STACKS + 1);
  localparam int FW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0] cnt_lim_r, hgt_lim_r;
  logic [SW-1:0]    front_r, front_nxt, back_r, back_nxt, new_back;
  logic [CW-1:0]    count_r, count_nxt, clim;
  logic [FW-1:0]    front_fill_r, front_fill_nxt, back_fill_r, back_fill_nxt;
  logic [FW-1:0]    hlim, pop_fill, pre_fill, fill_rdata, byp_fill_r;
  logic [SW-1:0]    fill_raddr;
  logic             fill_we, byp_r, need_open, ok;
  logic             res_valid_r;
  bqs_res_t         res_r;

  function automatic logic [SW-1:0] ring_inc(input logic [SW-1:0] i);
    if (i == SW'(MAX_STACKS - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_lim_r <= LIMIT_RESET;
      hgt_lim_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STACK_COUNT:  cnt_lim_r <= cfg_wdata;
        CFG_STACK_HEIGHT: hgt_lim_r <= cfg_wdata;
      endcase
    end
  end

  // clamp limits: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (cnt_lim_r == '0) begin
      clim = CW'(1);
    end else if (32'(cnt_lim_r) > MAX_STACKS) begin
      clim = CW'(MAX_STACKS);
    end else begin
      clim = CW'(cnt_lim_r);
    end
    if (hgt_lim_r == '0) begin
      hlim = FW'(1);
    end else if (32'(hgt_lim_r) > MAX_HEIGHT) begin
      hlim = FW'(MAX_HEIGHT);
    end else begin
      hlim = FW'(hgt_lim_r);
    end
  end

  // fill store: closed stacks keep their fill here; the stack behind the
  // front is read ahead every cycle so a retiring front finds its successor
  assign fill_raddr = ring_inc(front_nxt);

  bqs_ram #(
    .WIDTH(FW),
    .DEPTH(MAX_STACKS),
    .AW   (SW)
  ) u_fill_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(back_r),
    .wdata(back_fill_r),
    .raddr(fill_raddr),
    .rdata(fill_rdata)
  );

  // forward a fill written at the same edge as its read-ahead
  always_ff @(posedge clk) begin
    byp_r      <= fill_we && (back_r == fill_raddr);
    byp_fill_r <= back_fill_r;
  end

  assign pre_fill = byp_r ? byp_fill_r : fill_rdata;

  // next state for one item
  always_comb begin
    front_nxt      = front_r;
    back_nxt       = back_r;
    count_nxt      = count_r;
    front_fill_nxt = front_fill_r;
    back_fill_nxt  = back_fill_r;
    new_back       = (count_r == '0) ? front_r : ring_inc(back_r);
    need_open      = (count_r == '0) || (back_fill_r >= hlim);
    pop_fill       = front_fill_r - 1'b1;
    fill_we        = 1'b0;
    slot_we        = 1'b0;
    slot_waddr     = AW'(back_r) * AW'(MAX_HEIGHT) + AW'(back_fill_r);
    slot_raddr     = AW'(front_r) * AW'(MAX_HEIGHT) + AW'(pop_fill);
    ok             = 1'b0;
    if (in_accept) begin
      if (in_command == CMD_STORE) begin
        if (need_open && (count_r >= clim)) begin
          ok = 1'b0;
        end else if (need_open) begin
          // close the back stack and open a new one
          fill_we       = (count_r != '0);
          back_nxt      = new_back;
          back_fill_nxt = FW'(1);
          if (count_r == '0) begin
            front_fill_nxt = FW'(1);
          end
          count_nxt  = count_r + 1'b1;
          slot_we    = 1'b1;
          slot_waddr = AW'(new_back) * AW'(MAX_HEIGHT);
          ok         = 1'b1;
        end else begin
          // push onto the open back stack
          back_fill_nxt = back_fill_r + 1'b1;
          if (count_r == CW'(1)) begin
            front_fill_nxt = back_fill_r + 1'b1;
          end
          slot_we = 1'b1;
          ok      = 1'b1;
        end
      end else if (count_r != '0) begin
        // pop the front stack, retire it once empty
        ok = 1'b1;
        if (pop_fill == '0) begin
          front_nxt      = ring_inc(front_r);
          count_nxt      = count_r - 1'b1;
          front_fill_nxt = (count_r == CW'(2)) ? back_fill_r : pre_fill;
        end else begin
          front_fill_nxt = pop_fill;
          if (count_r == CW'(1)) begin
            back_fill_nxt = pop_fill;
          end
        end
      end
    end
  end

  assign slot_wdata = in_tag;

  // state registers and status of the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      res_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    front_fill_r   <= front_fill_nxt;
    back_fill_r    <= back_fill_nxt;
    res_r.ok       <= ok;
    res_r.tag_vld  <= ok && (in_command == CMD_DISPATCH);
    res_r.is_empty <= (count_nxt == '0);
    res_r.is_full  <= (count_nxt != '0) && (count_nxt >= clim) && (back_fill_nxt >= hlim);
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> rtl/bqs_outq.sv
// bqs_outq: two-entry result queue that parts the block from a stalling receiver
// depends on bqs_pkg
`timescale 1ns / 1ps

module bqs_outq import bqs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  bqs_res_t         res,
  input  logic [TAG_W-1:0] rdata,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_accepted,
  output logic [TAG_W-1:0] out_tag_out,
  output logic             out_is_empty,
  output logic             out_is_full,
  output logic             in_stall
);

  bqs_out_t   q_r [0:1];
  bqs_out_t   head, entry;
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic [2:0] held;
  logic       deq;

  assign deq = (cnt_r != '0) && !out_stall;

  // build the item: tag reads as zero unless a dispatch succeeded
  always_comb begin
    entry.ok       = res.ok;
    entry.tag      = res.tag_vld ? rdata : '0;
    entry.is_empty = res.is_empty;
    entry.is_full  = res.is_full;
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(res_valid) - 2'(deq);
    end
  end

  // hold off new items when the in-flight one would find no entry
  assign held     = 3'(cnt_r) + 3'(res_valid) - 3'(deq);
  assign in_stall = (held > 3'd1);

  assign head         = q_r[rd_ptr_r];
  assign out_valid    = (cnt_r != '0);
  assign out_accepted = head.ok;
  assign out_tag_out  = head.tag;
  assign out_is_empty = head.is_empty;
  assign out_is_full  = head.is_full;

endmodule

>>> rtl/bounded_queue_of_stacks_top.sv
// bounded_queue_of_stacks_top: FIFO queue of LIFO tag stacks, top level
// depends on bqs_pkg, bqs_ram, bqs_ctrl and bqs_outq
`timescale 1ns / 1ps

// Usage:
//   input channel: in_valid / in_stall carry one item (in_command, in_tag_in);
//   command store pushes the tag onto the back stack, dispatch pops the front.
//   result channel: out_valid / out_stall carry one result per item
//   (out_accepted, out_tag_out, out_is_empty, out_is_full).
//   cfg_we / cfg_index / cfg_wdata write the stack count and height limits;
//   write them only while no item is in flight.
// Timing:
//   one item per cycle sustained while in_stall stays low; every item touches
//   one tag slot and one fill entry, and the tag ram read and state update
//   happen at the edge that takes the item. Its result is registered in the
//   control stage, then written into the result queue that drives out_valid.
// Stall:
//   a two-entry result queue absorbs the receiver's stall; in_stall rises only
//   when that queue and the item in flight would overflow it.
// Reset:
//   rst_n low empties the queue of stacks and the result queue and sets both
//   limits to 16; tag and fill memories are not cleared and need no sweep.

module bounded_queue_of_stacks_top import bqs_pkg::*; #(
  parameter int MAX_STACKS = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [TAG_W-1:0] in_tag_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_accepted,
  output logic [TAG_W-1:0] out_tag_out,
  output logic             out_is_empty,
  output logic             out_is_full,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int SLOTS = MAX_STACKS * MAX_HEIGHT;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic             in_accept;
  logic             slot_we;
  logic [AW-1:0]    slot_waddr, slot_raddr;
  logic [TAG_W-1:0] slot_wdata, slot_rdata;
  logic             res_valid;
  bqs_res_t         res;

  assign in_accept = in_valid && !in_stall;

  // pointers, fills and limits
  bqs_ctrl #(
    .MAX_STACKS(MAX_STACKS),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_command(in_command),
    .in_tag    (in_tag_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .slot_we   (slot_we),
    .slot_waddr(slot_waddr),
    .slot_wdata(slot_wdata),
    .slot_raddr(slot_raddr),
    .res_valid (res_valid),
    .res       (res)
  );

  // tag slots, one row per stack
  bqs_ram #(
    .WIDTH(TAG_W),
    .DEPTH(SLOTS),
    .AW   (AW)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  // result queue
  bqs_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res         (res),
    .rdata       (slot_rdata),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_accepted(out_accepted),
    .out_tag_out (out_tag_out),
    .out_is_empty(out_is_empty),
    .out_is_full (out_is_full),
    .in_stall    (in_stall)
  );

endmodule

>>> rtl/bqs_checker.sv
// bqs_port_checker: port-level assertions for the bounded queue of stacks
// depends on bqs_pkg; bound to bounded_queue_of_stacks_top
`timescale 1ns / 1ps

module bqs_port_checker import bqs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_command,
  input logic [TAG_W-1:0] in_tag_in,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_accepted,
  input logic [TAG_W-1:0] out_tag_out,
  input logic             out_is_empty,
  input logic             out_is_full,
  input logic             cfg_we,
  input logic             cfg_index,
  input logic [CFG_W-1:0] cfg_wdata
);

  // reset drains the result queue
  a_reset_drains: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable({out_accepted, out_tag_out, out_is_empty, out_is_full}))
    else $error("stalled result changed");

  // refused or failed items carry no tag
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_tag_out == '0)
    else $error("tag on an unaccepted item");

  // full and empty never show together
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_full |-> !out_is_empty)
    else $error("full and empty at once");

endmodule

bind bounded_queue_of_stacks_top bqs_port_checker u_bqs_checker (.*);

>>> sim/bqs_checker.sv
// bqs_checker: watches the item, result and limit ports of the queue of stacks,
// predicts every result and compares it field by field; depends on bqs_pkg
`timescale 1ns / 1ps

module bqs_checker import bqs_pkg::*; #(
  parameter int MAX_STACKS = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_command,
  input  logic [TAG_W-1:0] in_tag_in,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_accepted,
  input  logic [TAG_W-1:0] out_tag_out,
  input  logic             out_is_empty,
  input  logic             out_is_full,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               errors,
  output int               pending
);

  // predicted copy of the queue of stacks
  logic [TAG_W-1:0] tag_slots [MAX_STACKS*MAX_HEIGHT];
  int unsigned      stack_depth [MAX_STACKS];
  int unsigned      oldest_stack;
  int unsigned      newest_stack;
  int unsigned      open_stacks;
  logic [CFG_W-1:0] count_limit_reg;
  logic [CFG_W-1:0] height_limit_reg;

  bqs_out_t awaited_results[$];
  int       mismatch_count = 0;

  assign errors = mismatch_count;

  // zero acts as one, anything past the parameter acts as the parameter
  function automatic int unsigned effective_limit(logic [CFG_W-1:0] raw, int unsigned top);
    if (raw == '0)
      return 1;
    return (raw > top) ? top : raw;
  endfunction

  // apply one store or dispatch to the predicted state and return its result
  function automatic bqs_out_t stack_queue_op(logic cmd, logic [TAG_W-1:0] tag);
    bqs_out_t    res;
    int unsigned clim;
    int unsigned hlim;
    int unsigned depth;
    logic        room;
    res  = '0;
    clim = effective_limit(count_limit_reg, MAX_STACKS);
    hlim = effective_limit(height_limit_reg, MAX_HEIGHT);
    if (cmd == CMD_STORE) begin
      room = 1'b1;
      // no stack yet, or back stack topped out: open a new one if allowed
      if (open_stacks == 0 || stack_depth[newest_stack] >= hlim) begin
        if (open_stacks >= clim) begin
          room = 1'b0;
        end else begin
          newest_stack = (open_stacks == 0) ? oldest_stack : (newest_stack + 1) % MAX_STACKS;
          stack_depth[newest_stack] = 0;
          open_stacks++;
        end
      end
      if (room && stack_depth[newest_stack] < MAX_HEIGHT) begin
        tag_slots[newest_stack*MAX_HEIGHT + stack_depth[newest_stack]] = tag;
        stack_depth[newest_stack]++;
        res.ok = 1'b1;
      end
    end else if (open_stacks != 0) begin
      depth = stack_depth[oldest_stack];
      if (depth != 0 && depth <= MAX_HEIGHT) begin
        depth--;
        res.tag = tag_slots[oldest_stack*MAX_HEIGHT + depth];
        stack_depth[oldest_stack] = depth;
        res.ok = 1'b1;
      end else begin
        depth = 0;
      end
      // front stack ran dry: retire it
      if (depth == 0) begin
        oldest_stack = (oldest_stack + 1) % MAX_STACKS;
        open_stacks--;
      end
    end
    res.is_empty = (open_stacks == 0);
    res.is_full  = (open_stacks != 0) && (open_stacks >= clim) &&
                   (stack_depth[newest_stack] >= hlim);
    return res;
  endfunction

  always @(posedge clk) begin
    bqs_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_STACKS; i++)
        stack_depth[i] = 0;
      for (int i = 0; i < MAX_STACKS*MAX_HEIGHT; i++)
        tag_slots[i] = '0;
      oldest_stack     = 0;
      newest_stack     = 0;
      open_stacks      = 0;
      count_limit_reg  = LIMIT_RESET;
      height_limit_reg = LIMIT_RESET;
      awaited_results.delete();
    end else begin
      // limit register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_STACK_COUNT:  count_limit_reg  = cfg_wdata;
          CFG_STACK_HEIGHT: height_limit_reg = cfg_wdata;
        endcase
      end
      // result side: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result item with nothing outstanding: ok=%0b tag=%h empty=%0b full=%0b",
                     $realtime, out_accepted, out_tag_out, out_is_empty, out_is_full);
        end else begin
          want = awaited_results.pop_front();
          if (out_accepted !== want.ok || out_tag_out !== want.tag ||
              out_is_empty !== want.is_empty || out_is_full !== want.is_full) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: expected ok=%0b tag=%h empty=%0b full=%0b, got ok=%0b tag=%h empty=%0b full=%0b",
                       $realtime, want.ok, want.tag, want.is_empty, want.is_full,
                       out_accepted, out_tag_out, out_is_empty, out_is_full);
          end
        end
      end
      // item side: predict
      if (in_valid && !in_stall)
        awaited_results.push_back(stack_queue_op(in_command, in_tag_in));
    end
    pending <= awaited_results.size();
  end

endmodule

>>> sim/testbench.sv
// testbench: drives items and limit writes into bounded_queue_of_stacks_top
// and gives the verdict; depends on bqs_pkg, the rtl and bqs_checker
`timescale 1ns / 1ps

module testbench;
  import bqs_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_command = CMD_STORE;
  logic [TAG_W-1:0] in_tag_in = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_accepted;
  logic [TAG_W-1:0] out_tag_out;
  logic             out_is_empty;
  logic             out_is_full;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_STACK_COUNT;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int errors;
  int pending;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  bounded_queue_of_stacks_top dut (.*);

  bqs_checker chk (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // hard stop
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  // offer one item and hold it until it is taken; idle cycle by cycle
  task automatic put_item(input logic cmd, input logic [TAG_W-1:0] tag);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_tag_in  <= tag;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // write both limits while nothing is in flight
  task automatic write_limits(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] height);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STACK_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_index <= CFG_STACK_HEIGHT;
    cfg_wdata <= height;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // bursts of stores and dispatches with random tags, plus single noise items
  task automatic run_mixed(input int n_items, input int store_pct);
    int   done;
    int   burst;
    logic cmd;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 80) begin
        burst = $urandom_range(1, 40);
        cmd   = ($urandom_range(99) < store_pct) ? CMD_STORE : CMD_DISPATCH;
      end else begin
        burst = 1;
        cmd   = $urandom_range(1) ? CMD_DISPATCH : CMD_STORE;
      end
      repeat (burst) put_item(cmd, TAG_W'($urandom));
      done += burst;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] count_set [10];
    logic [CFG_W-1:0] height_set [10];

    count_set  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd1, 5'd17, 5'd0, 5'd0};
    height_set = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd1, 5'd16, 5'd0, 5'd0, 5'd0};
    for (int i = 8; i < 10; i++) begin
      count_set[i]  = CFG_W'($urandom_range(0, 31));
      height_set[i] = CFG_W'($urandom_range(0, 31));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty dispatch, extreme tags, lifo order
    put_item(CMD_DISPATCH, 16'hFFFF);
    put_item(CMD_STORE, 16'h0000);
    put_item(CMD_STORE, 16'hFFFF);
    put_item(CMD_STORE, 16'h5555);
    put_item(CMD_STORE, 16'hAAAA);
    repeat (5) put_item(CMD_DISPATCH, 16'h0000);

    // one stack of two: full, refused store, empty again
    write_limits(5'd1, 5'd2);
    put_item(CMD_STORE, 16'h1234);
    put_item(CMD_STORE, 16'h4321);
    put_item(CMD_STORE, 16'h0F0F);
    repeat (3) put_item(CMD_DISPATCH, 16'h0000);

    // two stacks, then limits lowered under held data
    write_limits(5'd2, 5'd3);
    for (int i = 1; i <= 5; i++)
      put_item(CMD_STORE, 16'(i * 16'h1111));
    write_limits(5'd1, 5'd1);
    put_item(CMD_STORE, 16'hBEEF);
    repeat (2) put_item(CMD_DISPATCH, 16'h0000);

    // random phases over limit settings and idle patterns
    for (int p = 0; p < 10; p++) begin
      write_limits(count_set[p], height_set[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin sender_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (p == 0) begin
        // fill the whole store past full, then empty it past empty
        repeat (270) put_item(CMD_STORE, TAG_W'($urandom));
        repeat (270) put_item(CMD_DISPATCH, TAG_W'($urandom));
      end else begin
        run_mixed(75, 60);
        drain_results();
        run_mixed(75, 45);
      end
    end

    drain_results();
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
